// ----- rtl/mere_pkg.sv -----
// Shared types and constants for the midpoint ellipse rasterizer.
// Used by the shared arithmetic unit and the top level; no dependencies.
package mere_pkg;

	localparam int RADIUS_BITS_DEF = 8;
	localparam int COORD_BITS_DEF  = 12;

	localparam int RADIUS_IN_BITS = 8;
	localparam int CENTER_BITS    = 11;
	localparam int ORIGIN_BITS    = 10;
	localparam int COLOR_BITS     = 4;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 10;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X   = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PLOT_COLOR = 2'd2;

	localparam logic [ORIGIN_BITS-1:0] ORIGIN_X_RESET   = 10'd320;
	localparam logic [ORIGIN_BITS-1:0] ORIGIN_Y_RESET   = 10'd240;
	localparam logic [COLOR_BITS-1:0]  PLOT_COLOR_RESET = 4'd9;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL
	} alu_op_t;

endpackage

// ----- rtl/mere_alu.sv -----
// Shared arithmetic unit of the ellipse rasterizer: add, subtract, signed multiply.
// Depends on mere_pkg for the operation codes.
module mere_alu
	import mere_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  alu_op_t                        op,
	input  logic signed [4*RADIUS_BITS+7:0] a,
	input  logic signed [4*RADIUS_BITS+7:0] b,
	output logic signed [4*RADIUS_BITS+7:0] y
);

	localparam int MA = 2 * RADIUS_BITS + 7;
	localparam int MB = 2 * RADIUS_BITS + 1;

	logic signed [MA-1:0] mul_a;
	logic signed [MB-1:0] mul_b;

	assign mul_a = a[MA-1:0];
	assign mul_b = b[MB-1:0];

	always_comb begin
		unique case (op)
			ALU_ADD: y = a + b;
			ALU_SUB: y = a - b;
			ALU_MUL: y = mul_a * mul_b;
			default: y = a;
		endcase
	end

endmodule

// ----- rtl/midpoint_ellipse_rasterizer_unit.sv -----
// Top level of the midpoint ellipse rasterizer: sequencer, state and pixel output register.
// Depends on mere_pkg and mere_alu.

// A start beat loads the centre and radii and keeps the input stalled through the setup
// states, and through the region 2 setup as well when region 1 is left at once, using the
// shared add, subtract or multiply once per cycle. A step beat runs its region's arithmetic
// states, then the region 2 setup when the step leaves region 1, the end state that
// settles the end flag and its four pixel beats, which wait while the output stalls. The
// sequencer uses the single shared arithmetic unit in turn. The last pixel of a step may
// wait in the output register while the next input beat is taken.
module midpoint_ellipse_rasterizer_unit
	import mere_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_enable,
	input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             operation,
	input  logic signed [CENTER_BITS-1:0]    center_x,
	input  logic signed [CENTER_BITS-1:0]    center_y,
	input  logic [RADIUS_IN_BITS-1:0]        radius_x,
	input  logic [RADIUS_IN_BITS-1:0]        radius_y,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [COORD_BITS-1:0]     pixel_x,
	output logic signed [COORD_BITS-1:0]     pixel_y,
	output logic [COLOR_BITS-1:0]            color,
	output logic                             last_of_step,
	output logic                             ellipse_done
);

	localparam int R   = RADIUS_BITS;
	localparam int DW  = 4 * R + 8;
	localparam int SQW = 2 * R;
	localparam int XW  = R + 2;
	localparam int YW  = R + 2;
	localparam int CW  = COORD_BITS;
	localparam int RIN = (R < RADIUS_IN_BITS) ? R : RADIUS_IN_BITS;

	typedef enum logic [1:0] {
		R_IDLE,
		R_ONE,
		R_TWO
	} region_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RX2, S_RY2, S_T, S_D0, S_D1,
		S_CHK,
		S_A, S_P1, S_B, S_P2, S_ACC1, S_P3, S_ACC2, S_DIV,
		S1_PX, S1_D1, S1_D2, S1_PY, S1_D3,
		S2_PY, S2_D1, S2_D2, S2_PX, S2_D3,
		S_END, S_PIX
	} state_t;

	state_t                   state_q;
	region_t                  region_q;
	logic                     step_q;
	logic                     done_q;
	logic [1:0]               pix_k_q;
	logic [ORIGIN_BITS-1:0]   origin_x_q;
	logic [ORIGIN_BITS-1:0]   origin_y_q;
	logic [COLOR_BITS-1:0]    plot_color_q;

	logic signed [CENTER_BITS-1:0] cx_q;
	logic signed [CENTER_BITS-1:0] cy_q;
	logic [R-1:0]             rx_q;
	logic [R-1:0]             ry_q;
	logic [SQW-1:0]           rx2_q;
	logic [SQW-1:0]           ry2_q;
	logic [XW-1:0]            x_q;
	logic signed [YW-1:0]     y_q;
	logic [XW-1:0]            xo_q;
	logic signed [YW-1:0]     yo_q;
	logic signed [DW-1:0]     d_q;
	logic signed [DW-1:0]     px_q;
	logic signed [DW-1:0]     py_q;
	logic signed [DW-1:0]     tmp_q;
	logic                     dneg_q;
	logic                     dpos_q;

	logic                     accept;
	logic                     start_acc;
	logic                     step_acc;
	logic                     out_free;
	alu_op_t                  alu_op;
	logic signed [DW-1:0]     alu_a;
	logic signed [DW-1:0]     alu_b;
	logic signed [DW-1:0]     alu_y;
	logic signed [DW-1:0]     rx_e;
	logic signed [DW-1:0]     ry_e;
	logic signed [DW-1:0]     rx2_e;
	logic signed [DW-1:0]     ry2_e;
	logic signed [DW-1:0]     a_e;
	logic signed [DW-1:0]     b_e;
	logic signed [YW:0]       b_w;
	logic signed [DW-1:0]     two_rx2;
	logic signed [DW-1:0]     two_ry2;
	logic signed [DW-1:0]     div_bias;
	logic [R-1:0]             rx_in;
	logic [R-1:0]             ry_in;
	logic signed [CW-1:0]     base_x;
	logic signed [CW-1:0]     base_y;
	logic signed [CW-1:0]     off_x;
	logic signed [CW-1:0]     off_y;
	logic signed [CW-1:0]     pix_x;
	logic signed [CW-1:0]     pix_y;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign start_acc = accept && (operation == OP_START);
	assign step_acc  = accept && (operation == OP_STEP) && (region_q != R_IDLE);
	assign out_free  = !out_valid || !out_stall;

	assign rx_in = R'(radius_x[RIN-1:0]);
	assign ry_in = R'(radius_y[RIN-1:0]);

	assign rx_e     = DW'(rx_q);
	assign ry_e     = DW'(ry_q);
	assign rx2_e    = DW'(rx2_q);
	assign ry2_e    = DW'(ry2_q);
	assign two_rx2  = DW'({rx2_q, 1'b0});
	assign two_ry2  = DW'({ry2_q, 1'b0});
	assign a_e      = DW'({x_q, 1'b1});
	assign b_w      = (YW+1)'(y_q) - (YW+1)'(1);
	assign b_e      = DW'(b_w);
	assign div_bias = d_q[DW-1] ? DW'(3) : DW'(0);

	mere_alu #(
		.RADIUS_BITS(RADIUS_BITS)
	) u_alu (
		.op(alu_op),
		.a (alu_a),
		.b (alu_b),
		.y (alu_y)
	);

	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = d_q;
		alu_b  = '0;
		unique case (state_q)
			S_RX2:  begin alu_op = ALU_MUL; alu_a = rx_e;  alu_b = rx_e; end
			S_RY2:  begin alu_op = ALU_MUL; alu_a = ry_e;  alu_b = ry_e; end
			S_T:    begin alu_op = ALU_MUL; alu_a = rx2_e; alu_b = ry_e; end
			S_D0:   begin alu_op = ALU_SUB; alu_a = ry2_e; alu_b = tmp_q; end
			S_D1:   begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = DW'(rx2_q[SQW-1:2]); end
			S_CHK:  begin alu_op = ALU_SUB; alu_a = px_q;  alu_b = py_q; end
			S_A:    begin alu_op = ALU_MUL; alu_a = a_e;   alu_b = a_e; end
			S_P1:   begin alu_op = ALU_MUL; alu_a = tmp_q; alu_b = ry2_e; end
			S_B:    begin alu_op = ALU_MUL; alu_a = b_e;   alu_b = b_e; end
			S_P2:   begin alu_op = ALU_MUL; alu_a = tmp_q; alu_b = rx2_e; end
			S_ACC1: begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = {tmp_q[DW-3:0], 2'b00}; end
			S_P3:   begin alu_op = ALU_MUL; alu_a = rx2_e; alu_b = ry2_e; end
			S_ACC2: begin alu_op = ALU_SUB; alu_a = d_q;   alu_b = {tmp_q[DW-3:0], 2'b00}; end
			S_DIV:  begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = div_bias; end
			S1_PX:  begin alu_op = ALU_ADD; alu_a = px_q;  alu_b = two_ry2; end
			S1_D1:  begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = px_q; end
			S1_D2:  begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = ry2_e; end
			S1_PY:  begin alu_op = ALU_SUB; alu_a = py_q;  alu_b = two_rx2; end
			S1_D3:  begin alu_op = ALU_SUB; alu_a = d_q;   alu_b = py_q; end
			S2_PY:  begin alu_op = ALU_SUB; alu_a = py_q;  alu_b = two_rx2; end
			S2_D1:  begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = rx2_e; end
			S2_D2:  begin alu_op = ALU_SUB; alu_a = d_q;   alu_b = py_q; end
			S2_PX:  begin alu_op = ALU_ADD; alu_a = px_q;  alu_b = two_ry2; end
			S2_D3:  begin alu_op = ALU_ADD; alu_a = d_q;   alu_b = px_q; end
			default: begin alu_op = ALU_ADD; alu_a = d_q; alu_b = '0; end
		endcase
	end

	always_comb begin
		base_x = CW'(origin_x_q) + CW'(cx_q);
		base_y = CW'(origin_y_q) - CW'(cy_q);
		off_x  = CW'(xo_q);
		off_y  = CW'(yo_q);
		pix_x  = pix_k_q[0] ? (base_x - off_x) : (base_x + off_x);
		pix_y  = ((pix_k_q == 2'd0) || (pix_k_q == 2'd3)) ? (base_y - off_y) : (base_y + off_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			region_q     <= R_IDLE;
			step_q       <= 1'b0;
			done_q       <= 1'b0;
			pix_k_q      <= 2'd0;
			origin_x_q   <= ORIGIN_X_RESET;
			origin_y_q   <= ORIGIN_Y_RESET;
			plot_color_q <= PLOT_COLOR_RESET;
			out_valid    <= 1'b0;
			pixel_x      <= '0;
			pixel_y      <= '0;
			color        <= '0;
			last_of_step <= 1'b0;
			ellipse_done <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					CFG_ORIGIN_X:   origin_x_q   <= cfg_data[ORIGIN_BITS-1:0];
					CFG_ORIGIN_Y:   origin_y_q   <= cfg_data[ORIGIN_BITS-1:0];
					CFG_PLOT_COLOR: plot_color_q <= cfg_data[COLOR_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall && (state_q != S_PIX)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start_acc) begin
						state_q  <= S_RX2;
						region_q <= R_ONE;
						step_q   <= 1'b0;
					end else if (step_acc) begin
						step_q  <= 1'b1;
						state_q <= (region_q == R_ONE) ? S1_PX : S2_PY;
					end
				end
				S_RX2:  state_q <= S_RY2;
				S_RY2:  state_q <= S_T;
				S_T:    state_q <= S_D0;
				S_D0:   state_q <= S_D1;
				S_D1:   state_q <= S_CHK;
				S_CHK: begin
					if (alu_y[DW-1]) begin
						state_q <= step_q ? S_END : S_IDLE;
					end else begin
						state_q <= S_A;
					end
				end
				S_A:    state_q <= S_P1;
				S_P1:   state_q <= S_B;
				S_B:    state_q <= S_P2;
				S_P2:   state_q <= S_ACC1;
				S_ACC1: state_q <= S_P3;
				S_P3:   state_q <= S_ACC2;
				S_ACC2: state_q <= S_DIV;
				S_DIV: begin
					region_q <= R_TWO;
					state_q  <= step_q ? S_END : S_IDLE;
				end
				S1_PX:  state_q <= S1_D1;
				S1_D1:  state_q <= S1_D2;
				S1_D2:  state_q <= dneg_q ? S_CHK : S1_PY;
				S1_PY:  state_q <= S1_D3;
				S1_D3:  state_q <= S_CHK;
				S2_PY:  state_q <= S2_D1;
				S2_D1:  state_q <= S2_D2;
				S2_D2:  state_q <= dpos_q ? S_END : S2_PX;
				S2_PX:  state_q <= S2_D3;
				S2_D3:  state_q <= S_END;
				S_END: begin
					done_q  <= (region_q == R_TWO) && y_q[YW-1];
					if ((region_q == R_TWO) && y_q[YW-1]) begin
						region_q <= R_IDLE;
					end
					pix_k_q <= 2'd0;
					state_q <= S_PIX;
				end
				S_PIX: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						pixel_x      <= pix_x;
						pixel_y      <= pix_y;
						color        <= plot_color_q;
						last_of_step <= (pix_k_q == 2'd3);
						ellipse_done <= (pix_k_q == 2'd3) && done_q;
						pix_k_q      <= pix_k_q + 2'd1;
						if (pix_k_q == 2'd3) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_acc) begin
			cx_q <= center_x;
			cy_q <= center_y;
			rx_q <= rx_in;
			ry_q <= ry_in;
			x_q  <= '0;
			y_q  <= YW'(ry_in);
			px_q <= '0;
		end
		if (step_acc) begin
			xo_q   <= x_q;
			yo_q   <= y_q;
			dneg_q <= d_q[DW-1];
			dpos_q <= !d_q[DW-1] && (d_q != '0);
		end
		unique case (state_q)
			S_RX2:  rx2_q <= alu_y[SQW-1:0];
			S_RY2:  ry2_q <= alu_y[SQW-1:0];
			S_T:    tmp_q <= alu_y;
			S_D0:   d_q   <= alu_y;
			S_D1: begin
				d_q  <= alu_y;
				py_q <= {tmp_q[DW-2:0], 1'b0};
			end
			S_A:    tmp_q <= alu_y;
			S_P1:   d_q   <= alu_y;
			S_B:    tmp_q <= alu_y;
			S_P2:   tmp_q <= alu_y;
			S_ACC1: d_q   <= alu_y;
			S_P3:   tmp_q <= alu_y;
			S_ACC2: d_q   <= alu_y;
			S_DIV:  d_q   <= {{2{alu_y[DW-1]}}, alu_y[DW-1:2]};
			S1_PX: begin
				px_q <= alu_y;
				x_q  <= x_q + XW'(1);
			end
			S1_D1:  d_q <= alu_y;
			S1_D2:  d_q <= alu_y;
			S1_PY: begin
				py_q <= alu_y;
				y_q  <= y_q - YW'(1);
			end
			S1_D3:  d_q <= alu_y;
			S2_PY: begin
				py_q <= alu_y;
				y_q  <= y_q - YW'(1);
			end
			S2_D1:  d_q <= alu_y;
			S2_D2:  d_q <= alu_y;
			S2_PX: begin
				px_q <= alu_y;
				x_q  <= x_q + XW'(1);
			end
			S2_D3:  d_q <= alu_y;
			default: ;
		endcase
	end

	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		start_acc |=> (state_q == S_RX2) && (region_q == R_ONE))
		else $error("start beat did not enter the setup sequence");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ellipse_done |-> last_of_step)
		else $error("ellipse end flagged on a pixel that does not end its step");

	a_mid_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_step |-> (state_q == S_PIX))
		else $error("a step was left with pixels still to send");

	a_region_back: assert property (@(posedge clk) disable iff (!arst_n)
		($past(region_q) == R_TWO) && (region_q == R_ONE) |-> $past(start_acc))
		else $error("region 2 returned to region 1 without a start beat");

endmodule
